// ----- sv/bm25_pkg.sv -----
package bm25_pkg;

    // fixed-point formats
    localparam int LOG_FRAC  = 24;            // fraction bits of log, idf and ratio
    localparam int LOG_STEPS = 24;            // squaring steps, one fraction bit each
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    // datapath widths
    localparam int LOG_ARG_W = 19;            // 2*N+2 and 2*df+1 fit here
    localparam int LOG_R_W   = 29;            // integer part up to 18, plus 24 fraction bits
    localparam int IDF_W     = 29;
    localparam int PROD_W    = 52;            // avg length times term count
    localparam int DIV_W     = 57;            // dividend, divisor and remainder
    localparam int QUO_W     = 44;            // 20 integer bits, 24 fraction bits

    // field widths on the ports
    localparam int DF_W    = 17;
    localparam int LEN_W   = 20;
    localparam int SCORE_W = 32;
    localparam int CFG_W   = 32;

    // stage positions in the pipeline
    localparam int ST_NORM    = 1;
    localparam int ST_SETUP   = 2;
    localparam int ST_SQ_LAST = ST_SETUP + LOG_STEPS - 1;   // 25
    localparam int ST_LN      = ST_SQ_LAST + 1;             // 26
    localparam int ST_IDF     = ST_LN + 1;                  // 27
    localparam int ST_DIV_END = ST_SETUP + QUO_W;           // 46
    localparam int ST_MUL     = ST_DIV_END + 1;             // 47
    localparam int ST_OUT     = ST_MUL + 1;                 // 48

    typedef enum logic [1:0] {
        CFG_TOTAL_DOCS = 2'd0,
        CFG_AVG_LEN    = 2'd1,
        CFG_MODE       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic saturated;
        logic skipped;
    } t_out_user;

endpackage

// ----- sv/bm25_tfidf_posting_scorer.sv -----
// Posting scorer: takes one posting per cycle (document frequency, term count, document
// length, filter flag) and returns one Q16.16 score per posting, in order. With the mode
// register at 1 the block gives Okapi BM25 with k1 = 1.5 and b = 0.75, with it at 0 TF-IDF,
// tf/len * (ln((1+N)/(1+df)) + 1). A filtered-out posting or an empty document comes back
// with skipped set and a zero score; a score that overflows 32 bits is clipped to all ones
// with saturated set. The pipeline accepts a new item every cycle unless the output
// stalls, and the depth of the pipeline is set by the 44-step restoring divider
// that forms the term ratio, one quotient bit a stage, with the two 24-step log lanes
// running beside it. A stall at the output freezes the whole pipeline, so s_axis tready
// falls only while a result is waiting and m_axis tready is low. Configuration is written
// through a plain write port and must only change while the pipeline is empty.
module bm25_tfidf_posting_scorer #(
    parameter int DOC_COUNT_BITS  = 16,
    parameter int LENGTH_BITS     = 20,
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // docs_with_term[16:0], term_count[36:17],
                                          // doc_tokens[56:37], zero padding above
    input  logic [0:0]  i_s_axis_tuser,   // doc_allowed
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // score
    output logic [1:0]  o_m_axis_tuser,   // skipped[0], saturated[1]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    // effective field widths follow the parameters, ports stay fixed
    localparam int DW = (DOC_COUNT_BITS + 1 < bm25_pkg::DF_W) ?
                        DOC_COUNT_BITS + 1 : bm25_pkg::DF_W;
    localparam int LW = (LENGTH_BITS < bm25_pkg::LEN_W) ? LENGTH_BITS : bm25_pkg::LEN_W;
    localparam logic [bm25_pkg::DF_W-1:0]  DF_MASK  = bm25_pkg::DF_W'((64'd1 << DW) - 64'd1);
    localparam logic [bm25_pkg::LEN_W-1:0] LEN_MASK = bm25_pkg::LEN_W'((64'd1 << LW) - 64'd1);
    localparam int SCORE_SHIFT = bm25_pkg::LOG_FRAC - SCORE_FRAC_BITS;
    localparam int LAST = bm25_pkg::ST_OUT;

    // configuration registers
    logic [bm25_pkg::DF_W-1:0] r_cfg_total;
    logic [bm25_pkg::CFG_W-1:0] r_cfg_avg;
    logic                      r_cfg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_total <= '0;
            r_cfg_avg   <= 32'd4096;
            r_cfg_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (bm25_pkg::t_cfg_idx'(i_cfg_addr))
                bm25_pkg::CFG_TOTAL_DOCS: r_cfg_total <= i_cfg_data[bm25_pkg::DF_W-1:0];
                bm25_pkg::CFG_AVG_LEN:    r_cfg_avg   <= i_cfg_data;
                bm25_pkg::CFG_MODE:       r_cfg_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control: every stage moves together, frozen while the output waits
    logic w_adv;
    logic r_vld [0:LAST];
    logic r_skp [0:LAST];
    logic r_mode [0:bm25_pkg::ST_LN];

    assign w_adv           = !r_vld[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) r_vld[s] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int s = 1; s <= LAST; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // stage 0: input capture
    logic [bm25_pkg::DF_W-1:0]  w_in_df;
    logic [bm25_pkg::LEN_W-1:0] w_in_tf, w_in_len;
    logic [bm25_pkg::DF_W-1:0]  r0_df, r0_n;
    logic [bm25_pkg::LEN_W-1:0] r0_tf, r0_len;
    logic [bm25_pkg::CFG_W-1:0] r0_a;

    assign w_in_df  = i_s_axis_tdata[16:0]  & DF_MASK;
    assign w_in_tf  = i_s_axis_tdata[36:17] & LEN_MASK;
    assign w_in_len = i_s_axis_tdata[56:37] & LEN_MASK;

    // stage 1: log argument normalise, a*tf product
    logic [bm25_pkg::LOG_ARG_W-1:0] w_arg [0:1];
    logic [4:0]                     w_lk  [0:1];
    logic [bm25_pkg::PROD_W-1:0]    w_p;
    logic [bm25_pkg::PROD_W-1:0]    r1_p;
    logic [bm25_pkg::LEN_W-1:0]     r1_tf, r1_len;
    logic [bm25_pkg::CFG_W-1:0]     r1_a;

    always_comb begin
        if (r_mode[0]) begin
            w_arg[0] = {1'b0, r0_n, 1'b0} + bm25_pkg::LOG_ARG_W'(2);
            w_arg[1] = {1'b0, r0_df, 1'b1};
        end else begin
            w_arg[0] = {2'b0, r0_n} + bm25_pkg::LOG_ARG_W'(1);
            w_arg[1] = {2'b0, r0_df} + bm25_pkg::LOG_ARG_W'(1);
        end
        for (int l = 0; l < 2; l++) begin
            w_lk[l] = '0;
            for (int b = 0; b < bm25_pkg::LOG_ARG_W; b++)
                if (w_arg[l][b]) w_lk[l] = 5'(b);
        end
    end

    assign w_p = bm25_pkg::PROD_W'(r0_a) * bm25_pkg::PROD_W'(r0_tf);

    // log lanes: lane 0 numerator argument, lane 1 denominator argument
    logic [31:0]                  r_lm [0:1][bm25_pkg::ST_NORM:bm25_pkg::ST_SQ_LAST];
    logic [bm25_pkg::LOG_R_W-1:0] r_lr [0:1][bm25_pkg::ST_NORM:bm25_pkg::ST_SQ_LAST];
    logic [31:0]                  w_lm [0:1][bm25_pkg::ST_SETUP:bm25_pkg::ST_SQ_LAST];
    logic [bm25_pkg::LOG_R_W-1:0] w_lr [0:1][bm25_pkg::ST_SETUP:bm25_pkg::ST_SQ_LAST];

    // squaring the mantissa yields one log2 fraction bit per stage
    always_comb begin
        logic [63:0] v_sq;
        logic [32:0] v_t;
        for (int l = 0; l < 2; l++) begin
            for (int s = bm25_pkg::ST_SETUP; s <= bm25_pkg::ST_SQ_LAST; s++) begin
                v_sq = 64'(r_lm[l][s-1]) * 64'(r_lm[l][s-1]);
                v_t  = v_sq[63:31];
                if (v_t[32]) begin
                    w_lm[l][s] = v_t[32:1];
                    w_lr[l][s] = r_lr[l][s-1] |
                                 (bm25_pkg::LOG_R_W'(1) << (bm25_pkg::ST_SQ_LAST - s));
                end else begin
                    w_lm[l][s] = v_t[31:0];
                    w_lr[l][s] = r_lr[l][s-1];
                end
            end
        end
    end

    // ln = log2 * ln(2), then idf
    logic [60:0]                  w_ln_full [0:1];
    logic [bm25_pkg::LOG_R_W-1:0] r_ln [0:1];
    logic signed [30:0]           w_idf_d;
    logic [bm25_pkg::IDF_W-1:0]   r_idf [bm25_pkg::ST_IDF:bm25_pkg::ST_DIV_END];

    always_comb begin
        for (int l = 0; l < 2; l++)
            w_ln_full[l] = 61'(r_lr[l][bm25_pkg::ST_SQ_LAST]) * 61'(bm25_pkg::LN2_Q32);
        w_idf_d = signed'(31'(r_ln[0])) - signed'(31'(r_ln[1]));
        if (!r_mode[bm25_pkg::ST_LN])
            w_idf_d = w_idf_d + (31'sd1 <<< bm25_pkg::LOG_FRAC);
    end

    // ratio: restoring divider, dividend pre-shifted so the first remainder is below den
    logic [bm25_pkg::DIV_W-1:0] w_num, w_den;
    logic [bm25_pkg::DIV_W-1:0] r_den [bm25_pkg::ST_SETUP:bm25_pkg::ST_DIV_END-1];
    logic [bm25_pkg::DIV_W-1:0] r_rem [bm25_pkg::ST_SETUP:bm25_pkg::ST_DIV_END-1];
    logic [bm25_pkg::QUO_W-1:0] r_quo [bm25_pkg::ST_SETUP:bm25_pkg::ST_DIV_END];
    logic [bm25_pkg::DIV_W-1:0] w_rem [bm25_pkg::ST_SETUP+1:bm25_pkg::ST_DIV_END];
    logic [bm25_pkg::QUO_W-1:0] w_quo [bm25_pkg::ST_SETUP+1:bm25_pkg::ST_DIV_END];

    always_comb begin
        if (r_mode[bm25_pkg::ST_NORM]) begin
            // 20*A*tf over 8*A*tf + 3*A + 36864*len
            w_num = (bm25_pkg::DIV_W'(r1_p) << 4) + (bm25_pkg::DIV_W'(r1_p) << 2);
            w_den = (bm25_pkg::DIV_W'(r1_p) << 3) + bm25_pkg::DIV_W'(r1_a)
                  + (bm25_pkg::DIV_W'(r1_a) << 1) + (bm25_pkg::DIV_W'(r1_len) << 15)
                  + (bm25_pkg::DIV_W'(r1_len) << 12);
        end else begin
            w_num = bm25_pkg::DIV_W'(r1_tf);
            w_den = bm25_pkg::DIV_W'(r1_len);
        end
    end

    always_comb begin
        logic [bm25_pkg::DIV_W:0] v_t;
        for (int s = bm25_pkg::ST_SETUP + 1; s <= bm25_pkg::ST_DIV_END; s++) begin
            v_t = {r_rem[s-1], r_quo[s-1][bm25_pkg::QUO_W-1]};
            if (v_t >= {1'b0, r_den[s-1]}) begin
                w_rem[s] = bm25_pkg::DIV_W'(v_t - {1'b0, r_den[s-1]});
                w_quo[s] = {r_quo[s-1][bm25_pkg::QUO_W-2:0], 1'b1};
            end else begin
                w_rem[s] = v_t[bm25_pkg::DIV_W-1:0];
                w_quo[s] = {r_quo[s-1][bm25_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    // product ratio * idf split in integer and fraction halves, then scale and clip
    logic [48:0] r_pi;
    logic [52:0] r_pf;
    logic [49:0] w_prod, w_sc;
    logic        w_sat;
    logic [31:0] r_score;
    logic        r_sat;

    assign w_prod = 50'(r_pi) + 50'(r_pf[52:24]);
    assign w_sc   = w_prod >> SCORE_SHIFT;
    assign w_sat  = |w_sc[49:32];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 0
            r_skp[0]  <= !i_s_axis_tuser[0] || (w_in_len == '0);
            r_mode[0] <= r_cfg_mode;
            r0_df     <= w_in_df;
            r0_n      <= r_cfg_total & DF_MASK;
            r0_tf     <= w_in_tf;
            r0_len    <= w_in_len;
            r0_a      <= r_cfg_avg;
            for (int s = 1; s <= LAST; s++) r_skp[s] <= r_skp[s-1];
            for (int s = 1; s <= bm25_pkg::ST_LN; s++) r_mode[s] <= r_mode[s-1];
            // stage 1
            for (int l = 0; l < 2; l++) begin
                r_lm[l][bm25_pkg::ST_NORM] <= 32'(w_arg[l]) << (5'd31 - w_lk[l]);
                r_lr[l][bm25_pkg::ST_NORM] <= bm25_pkg::LOG_R_W'(w_lk[l]) << bm25_pkg::LOG_FRAC;
                for (int s = bm25_pkg::ST_SETUP; s <= bm25_pkg::ST_SQ_LAST; s++) begin
                    r_lm[l][s] <= w_lm[l][s];
                    r_lr[l][s] <= w_lr[l][s];
                end
                r_ln[l] <= w_ln_full[l][60:32];
            end
            r1_p   <= w_p;
            r1_tf  <= r0_tf;
            r1_len <= r0_len;
            r1_a   <= r0_a;
            // idf, clamped at zero, then delayed to meet the ratio
            r_idf[bm25_pkg::ST_IDF] <= w_idf_d[30] ? '0 : bm25_pkg::IDF_W'(w_idf_d);
            for (int s = bm25_pkg::ST_IDF + 1; s <= bm25_pkg::ST_DIV_END; s++)
                r_idf[s] <= r_idf[s-1];
            // divider
            r_den[bm25_pkg::ST_SETUP] <= w_den;
            r_rem[bm25_pkg::ST_SETUP] <= w_num >> (bm25_pkg::QUO_W - bm25_pkg::LOG_FRAC);
            r_quo[bm25_pkg::ST_SETUP] <= {w_num[bm25_pkg::QUO_W-bm25_pkg::LOG_FRAC-1:0],
                                          bm25_pkg::LOG_FRAC'(0)};
            for (int s = bm25_pkg::ST_SETUP + 1; s < bm25_pkg::ST_DIV_END; s++) begin
                r_den[s] <= r_den[s-1];
                r_rem[s] <= w_rem[s];
            end
            for (int s = bm25_pkg::ST_SETUP + 1; s <= bm25_pkg::ST_DIV_END; s++)
                r_quo[s] <= w_quo[s];
            // multiply and output
            r_pi <= 49'(r_quo[bm25_pkg::ST_DIV_END][43:24]) * 49'(r_idf[bm25_pkg::ST_DIV_END]);
            r_pf <= 53'(r_quo[bm25_pkg::ST_DIV_END][23:0]) * 53'(r_idf[bm25_pkg::ST_DIV_END]);
            if (r_skp[bm25_pkg::ST_MUL]) begin
                r_score <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_score <= w_sat ? '1 : w_sc[31:0];
                r_sat   <= w_sat;
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = r_score;
    assign o_m_axis_tuser  = {r_sat, r_skp[LAST]};

endmodule

// ----- sv/bm25_chk.sv -----
module bm25_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    bm25_pkg::t_out_user w_user;
    assign w_user = bm25_pkg::t_out_user'(o_m_axis_tuser);

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_user.skipped |-> o_m_axis_tdata == '0 && !w_user.saturated)
        else $error("skipped item with nonzero score or saturation");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_user.saturated |-> o_m_axis_tdata == '1)
        else $error("saturated item not at full scale");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind bm25_tfidf_posting_scorer bm25_chk u_chk (.*);
